// ----- hdl/uds_response_signal_extract_defines.svh -----
// Assertion macros used by the checker file of the signal extractor
`ifndef UDS_RESPONSE_SIGNAL_EXTRACT_DEFINES_SVH
`define UDS_RESPONSE_SIGNAL_EXTRACT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define UDS_RSE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define UDS_RSE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/uds_rse_pkg.sv -----
// Shared constants, register codes and types of the response signal extractor
`default_nettype none
package uds_rse_pkg;

    localparam int MAX_RESPONSE = 64;
    localparam int CNT_W        = $clog2(MAX_RESPONSE + 1);
    // wide enough for count, and for start + 3 + length
    localparam int SUM_W        = ((CNT_W > 7) ? CNT_W : 7) + 2;

    localparam logic [7:0] RDBI_POS_RESP = 8'h62;
    localparam int         HDR_LEN       = 3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SELECT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q16      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Q16     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LENGTH = 3'd5;

    typedef struct packed {
        logic [5:0]         start_byte;
        logic [6:0]         field_length;
        logic signed [5:0]  bit_select;
        logic signed [31:0] scale_q16;
        logic signed [31:0] offset_q16;
        logic [6:0]         request_length;
    } cfg_t;

    typedef struct packed {
        logic        decode_ok;
        logic [31:0] raw_value;
    } field_t;

endpackage
`default_nettype wire

// ----- hdl/uds_rse_cfg.sv -----
// Configuration register file of the response signal extractor
`default_nettype none
module uds_rse_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [uds_rse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                        cfg_data,
    output uds_rse_pkg::cfg_t                       cfg
);
    import uds_rse_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_START_BYTE:     cfg_next.start_byte     = cfg_data[5:0];
                REG_FIELD_LENGTH:   cfg_next.field_length   = cfg_data[6:0];
                REG_BIT_SELECT:     cfg_next.bit_select     = $signed(cfg_data[5:0]);
                REG_SCALE_Q16:      cfg_next.scale_q16      = $signed(cfg_data);
                REG_OFFSET_Q16:     cfg_next.offset_q16     = $signed(cfg_data);
                REG_REQUEST_LENGTH: cfg_next.request_length = cfg_data[6:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte     <= 6'd0;
            cfg_reg.field_length   <= 7'd0;
            cfg_reg.bit_select     <= -6'sd1;
            cfg_reg.scale_q16      <= 32'sd65536;
            cfg_reg.offset_q16     <= 32'sd0;
            cfg_reg.request_length <= 7'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/uds_rse_gather.sv -----
// Byte gathering, window check and bit selection, registered per response
`default_nettype none
module uds_rse_gather (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  uds_rse_pkg::cfg_t        cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          resp_byte,
    input  wire logic                last_byte,
    input  wire logic                transfer_failed,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output uds_rse_pkg::field_t      out_field
);
    import uds_rse_pkg::*;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       first_byte_reg, first_byte_next;
    logic [31:0]      accum_plain_reg, accum_plain_next;
    logic [31:0]      accum_hdr_reg, accum_hdr_next;
    logic             valid_reg, valid_next;
    field_t           field_reg, field_next;

    logic             accept;
    logic             stored;
    logic [SUM_W-1:0] idx, s_ext, len_ext, hdr_ext, win_end, need;
    logic             header;
    logic             ok;
    logic [31:0]      raw_win, raw_shift;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_field = field_reg;

    always_comb begin
        stored  = byte_count_reg < CNT_W'(MAX_RESPONSE);
        idx     = SUM_W'(byte_count_reg);
        s_ext   = SUM_W'(cfg.start_byte);
        len_ext = SUM_W'(cfg.field_length);
        hdr_ext = SUM_W'(HDR_LEN);
        win_end = s_ext + len_ext;

        byte_count_next  = byte_count_reg;
        first_byte_next  = first_byte_reg;
        accum_plain_next = accum_plain_reg;
        accum_hdr_next   = accum_hdr_reg;
        if (stored) begin
            byte_count_next = byte_count_reg + CNT_W'(1);
            if (byte_count_reg == '0) begin
                first_byte_next = resp_byte;
            end
            if (idx >= s_ext && idx < win_end) begin
                accum_plain_next = {accum_plain_reg[23:0], resp_byte};
            end
            if (idx >= s_ext + hdr_ext && idx < win_end + hdr_ext) begin
                accum_hdr_next = {accum_hdr_reg[23:0], resp_byte};
            end
        end

        header = byte_count_next >= CNT_W'(HDR_LEN) && first_byte_next == RDBI_POS_RESP;
        need   = (header ? hdr_ext : '0) + win_end;
        ok     = !transfer_failed && cfg.request_length != 7'd0 && cfg.field_length != 7'd0
                 && need <= SUM_W'(byte_count_next);

        raw_win   = header ? accum_hdr_next : accum_plain_next;
        raw_shift = raw_win >> cfg.bit_select[4:0];

        field_next.decode_ok = ok;
        if (!ok) begin
            field_next.raw_value = '0;
        end else if (!cfg.bit_select[5]) begin
            field_next.raw_value = {31'd0, raw_shift[0]};
        end else begin
            field_next.raw_value = raw_win;
        end

        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = accept && last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            first_byte_reg  <= '0;
            accum_plain_reg <= '0;
            accum_hdr_reg   <= '0;
            valid_reg       <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                if (last_byte) begin
                    // response done: start the next one from empty
                    byte_count_reg  <= '0;
                    first_byte_reg  <= '0;
                    accum_plain_reg <= '0;
                    accum_hdr_reg   <= '0;
                end else begin
                    byte_count_reg  <= byte_count_next;
                    first_byte_reg  <= first_byte_next;
                    accum_plain_reg <= accum_plain_next;
                    accum_hdr_reg   <= accum_hdr_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && last_byte) begin
            field_reg <= field_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/uds_rse_scale.sv -----
// Q16.16 scale and offset: product register, then saturating sum into the result register
`default_nettype none
module uds_rse_scale (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  uds_rse_pkg::cfg_t        cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  uds_rse_pkg::field_t      in_field,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     out_decode_ok,
    output logic [31:0]              out_raw_value,
    output logic signed [63:0]       out_scaled_value_q16
);
    import uds_rse_pkg::*;

    localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

    logic               prod_valid_reg;
    field_t             prod_field_reg;
    logic signed [63:0] prod_reg;
    logic signed [64:0] prod_full;

    logic               res_valid_reg;
    logic               ok_reg;
    logic [31:0]        raw_reg;
    logic signed [63:0] scaled_reg, scaled_next;
    logic signed [64:0] sum_full;

    logic               res_ready;
    logic               prod_ready;

    assign res_ready  = !res_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || res_ready;
    assign in_ready   = prod_ready;

    assign prod_full = 65'($signed({1'b0, in_field.raw_value})) * 65'(cfg.scale_q16);

    always_comb begin
        sum_full = 65'(prod_reg) + 65'(cfg.offset_q16);
        if (!prod_field_reg.decode_ok) begin
            scaled_next = '0;
        end else if (sum_full[64] != sum_full[63]) begin
            scaled_next = sum_full[64] ? SAT_MIN : SAT_MAX;
        end else begin
            scaled_next = sum_full[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (res_ready) begin
                res_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid) begin
            prod_field_reg <= in_field;
            prod_reg       <= prod_full[63:0];
        end
        if (res_ready && prod_valid_reg) begin
            ok_reg     <= prod_field_reg.decode_ok;
            raw_reg    <= prod_field_reg.raw_value;
            scaled_reg <= scaled_next;
        end
    end

    assign out_valid            = res_valid_reg;
    assign out_decode_ok        = ok_reg;
    assign out_raw_value        = raw_reg;
    assign out_scaled_value_q16 = scaled_reg;

endmodule
`default_nettype wire

// ----- hdl/uds_response_signal_extract.sv -----
// Top level of the diagnostic response signal extractor
//
// Input channel (s_): one response byte per beat, with s_last_byte marking the
// final byte and s_transfer_failed qualifying that final byte. Result channel
// (m_): one beat per response, carrying decode_ok, the raw field and the scaled
// Q16.16 value. Bytes that are not last produce no result beat.
// Configuration channel (cfg_): register index and data, always ready; write
// only while no response is in flight.
// Throughput: one byte per cycle while m_ready is high, also across responses.
// Result path: the gather register loads with the last byte, then the product
// register, then the result register, which drives m_valid.
// When the receiver holds m_ready low the result stays on the port and the
// stages behind it fill; s_ready drops only once all three are occupied.
// Reset (aresetn low, synchronous) empties the pipeline, clears the partial
// response and restores the register defaults.
`default_nettype none
module uds_response_signal_extract (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [7:0]                         s_resp_byte,
    input  wire logic                               s_last_byte,
    input  wire logic                               s_transfer_failed,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_decode_ok,
    output logic [31:0]                             m_raw_value,
    output logic signed [63:0]                      m_scaled_value_q16,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [uds_rse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                        cfg_data
);
    import uds_rse_pkg::*;

    cfg_t   cfg;
    field_t field;
    logic   field_valid;
    logic   field_ready;

    uds_rse_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uds_rse_gather u_gather (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .resp_byte       (s_resp_byte),
        .last_byte       (s_last_byte),
        .transfer_failed (s_transfer_failed),
        .out_valid       (field_valid),
        .out_ready       (field_ready),
        .out_field       (field)
    );

    uds_rse_scale u_scale (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg                  (cfg),
        .in_valid             (field_valid),
        .in_ready             (field_ready),
        .in_field             (field),
        .out_valid            (m_valid),
        .out_ready            (m_ready),
        .out_decode_ok        (m_decode_ok),
        .out_raw_value        (m_raw_value),
        .out_scaled_value_q16 (m_scaled_value_q16)
    );

endmodule
`default_nettype wire

// ----- hdl/uds_rse_checker.sv -----
// Port-level checker of the signal extractor and its bind
`default_nettype none
`include "uds_response_signal_extract_defines.svh"
module uds_rse_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_decode_ok,
    input wire logic [31:0]        m_raw_value,
    input wire logic signed [63:0] m_scaled_value_q16
);

    `UDS_RSE_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_decode_ok) && $stable(m_raw_value) && $stable(m_scaled_value_q16), "result beat changed while stalled")

    `UDS_RSE_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_valid && !m_decode_ok, m_raw_value == 32'd0 && m_scaled_value_q16 == 64'sd0, "failed decode carries non-zero payload")

    `UDS_RSE_ASSERT_NOW(a_idle_ready, aclk, aresetn, !m_valid, s_ready, "input stalled with empty result register")

    `UDS_RSE_ASSERT_NOW(a_drain_ready, aclk, aresetn, m_valid && m_ready, s_ready, "input stalled while result drains")

endmodule

bind uds_response_signal_extract uds_rse_checker u_uds_rse_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_decode_ok        (m_decode_ok),
    .m_raw_value        (m_raw_value),
    .m_scaled_value_q16 (m_scaled_value_q16)
);
`default_nettype wire
